/* sv/ust_pkg.sv */
// ust_pkg: shared constants for the unordered set table
// opcodes, status codes and fixed field widths; no dependencies
package ust_pkg;

  localparam int KEY_W   = 32;
  localparam int FIELD_W = 7;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  localparam logic [FIELD_W-1:0] CAP_RESET = 7'd64;

endpackage

/* sv/ust_ram.sv */
// ust_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module ust_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/unordered_set_table.sv */
// unordered_set_table: set of 32-bit keys in an unordered table with a fill count
// depends on ust_pkg and ust_ram
//
// usage: pulse start with opcode and value while busy is low; the item is
// taken at that edge and busy rises the next cycle. cfg_we writes
// capacity_limit (clamped to MAX_ENTRIES); write it only while idle.
// one result per item: done is high for exactly one cycle with found,
// position, count and status valid; the receiver cannot hold it off.
// the search walks the table one entry per cycle through the ram read port:
// a hit at index p is reported once entry p is compared, a miss once all
// count entries are compared. a delete then shifts the later entries down,
// one entry per cycle over the same ports. a new item may be started
// in the cycle done is shown. reset empties the set (fill count zero; the
// count output is not reset) and sets the limit to 64; the ram contents are
// not cleared, only entries below the count are ever used.
module unordered_set_table import ust_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               opcode,
  input  logic signed [KEY_W-1:0]  value,
  input  logic                     cfg_we,
  input  logic [FIELD_W-1:0]       cfg_wdata,
  output logic                     done,
  output logic                     found,
  output logic [FIELD_W-1:0]       position,
  output logic [FIELD_W-1:0]       count,
  output logic                     status
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = (CW > FIELD_W) ? CW : FIELD_W;
  localparam logic [LW-1:0] MAX_L = LW'(MAX_ENTRIES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;

  logic [1:0]       state;
  logic [1:0]       op_r;
  logic [KEY_W-1:0] key_r;
  logic [CW-1:0]    fill;
  logic [FIELD_W-1:0] cap;
  logic [CW-1:0]    rd_idx;
  logic [CW-1:0]    cmp_idx;
  logic             cmp_valid;
  logic [CW-1:0]    sh_rd;
  logic [CW-1:0]    sh_wa;
  logic             sh_wv;

  logic [LW-1:0]    cap_l;
  logic [LW-1:0]    lim_l;
  logic             can_insert;
  logic             hit;
  logic             last_cmp;
  logic             miss;
  logic [CW-1:0]    cmp_next;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  assign busy = (state != S_IDLE);

  // limit clamp and hit/miss detection
  assign cap_l      = LW'(cap);
  assign lim_l      = (cap_l > MAX_L) ? MAX_L : cap_l;
  assign can_insert = (LW'(fill) < lim_l);
  assign cmp_next   = cmp_idx + CW'(1);
  assign hit        = (state == S_SEARCH) && cmp_valid && (ram_rdata == key_r);
  assign last_cmp   = cmp_valid ? (cmp_next == fill) : (fill == '0);
  assign miss       = (state == S_SEARCH) && !hit && last_cmp;

  assign ram_raddr = (state == S_SHIFT) ? sh_rd[AW-1:0] : rd_idx[AW-1:0];
  assign ram_we    = ((state == S_SHIFT) && sh_wv) ||
                     (miss && (op_r == OP_INSERT) && can_insert);
  assign ram_waddr = (state == S_SHIFT) ? sh_wa[AW-1:0] : fill[AW-1:0];
  assign ram_wdata = (state == S_SHIFT) ? ram_rdata : key_r;

  ust_ram #(
    .WIDTH(KEY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      cap       <= CAP_RESET;
      done      <= 1'b0;
      cmp_valid <= 1'b0;
      sh_wv     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_r      <= opcode;
            key_r     <= value;
            rd_idx    <= '0;
            cmp_valid <= 1'b0;
            state     <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          rd_idx    <= rd_idx + CW'(1);
          cmp_idx   <= rd_idx;
          cmp_valid <= 1'b1;
          if (hit) begin
            found    <= 1'b1;
            position <= FIELD_W'(cmp_idx);
            status   <= STATUS_OK;
            if (op_r == OP_DELETE) begin
              if (cmp_next != fill) begin
                sh_rd <= cmp_next;
                sh_wv <= 1'b0;
                state <= S_SHIFT;
              end else begin
                fill  <= fill - CW'(1);
                count <= FIELD_W'(fill - CW'(1));
                done  <= 1'b1;
                state <= S_IDLE;
              end
            end else begin
              count <= FIELD_W'(fill);
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end else if (miss) begin
            found    <= 1'b0;
            position <= FIELD_W'(fill);
            if ((op_r == OP_INSERT) && can_insert) begin
              fill   <= fill + CW'(1);
              count  <= FIELD_W'(fill + CW'(1));
              status <= STATUS_OK;
            end else if (op_r == OP_INSERT) begin
              count  <= FIELD_W'(fill);
              status <= STATUS_FULL;
            end else begin
              count  <= FIELD_W'(fill);
              status <= STATUS_OK;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SHIFT: begin
          // read entry sh_rd, write it one place down next cycle
          if (sh_rd != fill) begin
            sh_wa <= sh_rd - CW'(1);
            sh_wv <= 1'b1;
            sh_rd <= sh_rd + CW'(1);
          end else begin
            sh_wv <= 1'b0;
            fill  <= fill - CW'(1);
            count <= FIELD_W'(fill - CW'(1));
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sv/ust_checker.sv */
// ust_checker: port-level assertions for unordered_set_table, with its bind
// depends on ust_pkg
module ust_checker import ust_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               found,
  input logic [FIELD_W-1:0] position,
  input logic [FIELD_W-1:0] count,
  input logic               status
);

  // a result only follows a cycle of work
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a preceding busy cycle");

  // an accepted item always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // a refused insert reports a miss at the unchanged count
  a_full_miss: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STATUS_FULL)) |-> (!found && (position == count)))
    else $error("refused insert with inconsistent fields");

  // results are never back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

endmodule

bind unordered_set_table ust_checker u_ust_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .found   (found),
  .position(position),
  .count   (count),
  .status  (status)
);
